// ===== rtl/core/stsd_pkg.sv =====
`default_nettype none
package stsd_pkg;

    localparam int unsigned HDR_WORDS = 6;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QAW       = $clog2(QDEPTH);

    // register indexes on the configuration channel
    localparam logic [2:0] CFG_RANGE_START = 3'd0;
    localparam logic [2:0] CFG_RANGE_END   = 3'd1;
    localparam logic [2:0] CFG_BYTE_SWAP   = 3'd2;
    localparam logic [2:0] CFG_CLIP        = 3'd3;
    localparam logic [2:0] CFG_MAX_COUNT   = 3'd4;

    // section kinds
    localparam logic [1:0] KIND_RANGE = 2'd0;
    localparam logic [1:0] KIND_VAR   = 2'd1;
    localparam logic [1:0] KIND_FIXED = 2'd2;

    // header type codes
    localparam logic [7:0] TYPE_RANGE = 8'd1;
    localparam logic [7:0] TYPE_VAR   = 8'd2;
    localparam logic [7:0] TYPE_FIXED = 8'd3;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ITEM,
        ACT_ERROR
    } act_t;

    // one decoded request between front and back
    typedef struct packed {
        logic        clr;
        act_t        act;
        logic [31:0] start;
        logic [31:0] stop;
        logic [31:0] value;
        logic [1:0]  kind;
    } entry_t;

    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic        clip;
        logic [30:0] max_count;
    } back_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/signal_track_section_decoder.sv =====
`default_nettype none
// Channel   Direction  Handshake                  Payload
// s_        in         s_tvalid / s_tready        s_tdata: word; s_tuser: flags
// m_        out        m_tvalid / m_tready        m_tdata: interval; m_tuser: kind, error
// cfg_      in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One section word is taken per cycle while the four-entry request queue has room.
// The front decodes the word in the cycle it is taken and queues any request; the back
// pops each queued request, applies the range compare and count limit, then holds the
// result in an output register. Reset is synchronous: it empties the queue and
// output register and restores register defaults. A stalled output fills the queue,
// then drops s_tready.
module signal_track_section_decoder (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] word
    input  wire logic [1:0]   s_tuser,   // [0] block_first, [1] query_first
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // [31:0] interval_start, [63:32] interval_end,
                                         // [95:64] value_bits
    output logic [2:0]        m_tuser,   // [1:0] section_kind, [2] format_error
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    logic [31:0] range_start_reg;
    logic [31:0] range_end_reg;
    logic        byte_swap_reg;
    logic        clip_reg;
    logic [30:0] max_count_reg;

    stsd_pkg::back_cfg_t back_cfg;
    stsd_pkg::entry_t    push_entry;
    stsd_pkg::entry_t    pop_entry;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_not_empty;
    logic                s_accept;
    logic [31:0]         out_start;
    logic [31:0]         out_end;
    logic [31:0]         out_value;
    logic [1:0]          out_kind;
    logic                out_error;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg   <= '1;
            byte_swap_reg   <= 1'b0;
            clip_reg        <= 1'b1;
            max_count_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                stsd_pkg::CFG_RANGE_START: range_start_reg <= cfg_data;
                stsd_pkg::CFG_RANGE_END:   range_end_reg   <= cfg_data;
                stsd_pkg::CFG_BYTE_SWAP:   byte_swap_reg   <= cfg_data[0];
                stsd_pkg::CFG_CLIP:        clip_reg        <= cfg_data[0];
                stsd_pkg::CFG_MAX_COUNT:   max_count_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        back_cfg.range_start = range_start_reg;
        back_cfg.range_end   = range_end_reg;
        back_cfg.clip        = clip_reg;
        back_cfg.max_count   = max_count_reg;
    end

    stsd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_swapped   (byte_swap_reg),
        .in_valid       (s_accept),
        .in_word        (s_tdata),
        .in_block_first (s_tuser[0]),
        .in_query_first (s_tuser[1]),
        .push_entry     (push_entry),
        .push           (push)
    );

    stsd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (q_not_empty)
    );

    stsd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (back_cfg),
        .q_not_empty (q_not_empty),
        .q_entry     (pop_entry),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_start   (out_start),
        .out_end     (out_end),
        .out_value   (out_value),
        .out_kind    (out_kind),
        .out_error   (out_error)
    );

    assign m_tdata = {out_value, out_end, out_start};
    assign m_tuser = {out_error, out_kind};

endmodule
`default_nettype wire

// ===== rtl/core/stsd_front.sv =====
`default_nettype none
module stsd_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             byte_swapped,
    input  wire logic             in_valid,
    input  wire logic [31:0]      in_word,
    input  wire logic             in_block_first,
    input  wire logic             in_query_first,
    output stsd_pkg::entry_t      push_entry,
    output logic                  push
);

    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [1:0]  item_idx_reg, item_idx_next;
    logic [15:0] items_left_reg, items_left_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] step_reg, step_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] fixed_start_reg, fixed_start_next;
    logic [31:0] held_start_reg, held_start_next;
    logic [31:0] held_end_reg, held_end_next;
    logic        skip_reg, skip_next;

    logic [31:0] d;
    logic [7:0]  hdr_type;
    logic [15:0] hdr_count;
    logic [2:0]  hdr_idx_eff;
    logic [1:0]  item_idx_eff;
    logic [15:0] items_left_eff;
    logic        skip_eff;

    always_comb begin
        d = byte_swapped ? {in_word[7:0], in_word[15:8], in_word[23:16], in_word[31:24]}
                         : in_word;
        hdr_type  = in_word[7:0];
        hdr_count = byte_swapped ? {in_word[23:16], in_word[31:24]} : in_word[31:16];

        // a new section abandons whatever is in progress
        hdr_idx_eff    = in_block_first ? 3'd0 : hdr_idx_reg;
        item_idx_eff   = in_block_first ? 2'd0 : item_idx_reg;
        items_left_eff = in_block_first ? 16'd0 : items_left_reg;
        skip_eff       = in_block_first ? 1'b0 : skip_reg;

        hdr_idx_next     = hdr_idx_eff;
        item_idx_next    = item_idx_eff;
        items_left_next  = items_left_eff;
        kind_next        = kind_reg;
        step_next        = step_reg;
        span_next        = span_reg;
        fixed_start_next = fixed_start_reg;
        held_start_next  = held_start_reg;
        held_end_next    = held_end_reg;
        skip_next        = skip_eff;

        push_entry       = '0;
        push_entry.clr   = in_query_first;
        push_entry.act   = stsd_pkg::ACT_NONE;
        push_entry.kind  = kind_reg;
        push_entry.value = d;

        if (hdr_idx_eff < 3'(stsd_pkg::HDR_WORDS)) begin
            hdr_idx_next = hdr_idx_eff + 3'd1;
            case (hdr_idx_eff)
                3'd1: fixed_start_next = d;
                3'd3: step_next = d;
                3'd4: span_next = d;
                3'd5: begin
                    item_idx_next = 2'd0;
                    if (hdr_type == stsd_pkg::TYPE_RANGE || hdr_type == stsd_pkg::TYPE_VAR
                        || hdr_type == stsd_pkg::TYPE_FIXED) begin
                        kind_next       = 2'(hdr_type - 8'd1);
                        items_left_next = hdr_count;
                        skip_next       = 1'b0;
                    end else begin
                        items_left_next  = 16'd0;
                        skip_next        = 1'b1;
                        push_entry.act   = stsd_pkg::ACT_ERROR;
                        push_entry.value = '0;
                        push_entry.kind  = '0;
                    end
                end
                default: ;
            endcase
        end else if (!skip_eff && items_left_eff != 16'd0) begin
            case (kind_reg)
                stsd_pkg::KIND_RANGE: begin
                    if (item_idx_eff == 2'd0) begin
                        held_start_next = d;
                        item_idx_next   = 2'd1;
                    end else if (item_idx_eff == 2'd1) begin
                        held_end_next = d;
                        item_idx_next = 2'd2;
                    end else begin
                        push_entry.act   = stsd_pkg::ACT_ITEM;
                        push_entry.start = held_start_reg;
                        push_entry.stop  = held_end_reg;
                        item_idx_next    = 2'd0;
                        items_left_next  = items_left_eff - 16'd1;
                    end
                end
                stsd_pkg::KIND_VAR: begin
                    if (item_idx_eff == 2'd0) begin
                        held_start_next = d;
                        item_idx_next   = 2'd1;
                    end else begin
                        push_entry.act   = stsd_pkg::ACT_ITEM;
                        push_entry.start = held_start_reg;
                        push_entry.stop  = held_start_reg + span_reg;
                        item_idx_next    = 2'd0;
                        items_left_next  = items_left_eff - 16'd1;
                    end
                end
                stsd_pkg::KIND_FIXED: begin
                    push_entry.act   = stsd_pkg::ACT_ITEM;
                    push_entry.start = fixed_start_reg;
                    push_entry.stop  = fixed_start_reg + span_reg;
                    fixed_start_next = fixed_start_reg + step_reg;
                    item_idx_next    = 2'd0;
                    items_left_next  = items_left_eff - 16'd1;
                end
                default: begin
                    item_idx_next   = 2'd0;
                    items_left_next = items_left_eff - 16'd1;
                end
            endcase
        end

        // forward only words that produce a result or clear the count
        push = in_valid && (push_entry.act != stsd_pkg::ACT_NONE || in_query_first);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_idx_reg     <= '0;
            item_idx_reg    <= '0;
            items_left_reg  <= '0;
            kind_reg        <= '0;
            step_reg        <= '0;
            span_reg        <= '0;
            fixed_start_reg <= '0;
            held_start_reg  <= '0;
            held_end_reg    <= '0;
            skip_reg        <= 1'b0;
        end else if (in_valid) begin
            hdr_idx_reg     <= hdr_idx_next;
            item_idx_reg    <= item_idx_next;
            items_left_reg  <= items_left_next;
            kind_reg        <= kind_next;
            step_reg        <= step_next;
            span_reg        <= span_next;
            fixed_start_reg <= fixed_start_next;
            held_start_reg  <= held_start_next;
            held_end_reg    <= held_end_next;
            skip_reg        <= skip_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/stsd_fifo.sv =====
`default_nettype none
module stsd_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire stsd_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output stsd_pkg::entry_t      pop_entry,
    output logic                  not_empty
);

    stsd_pkg::entry_t mem_reg [stsd_pkg::QDEPTH];

    logic [stsd_pkg::QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [stsd_pkg::QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [stsd_pkg::QAW:0]   count_reg, count_next;
    logic                     do_push;
    logic                     do_pop;

    always_comb begin
        full      = count_reg == (stsd_pkg::QAW+1)'(stsd_pkg::QDEPTH);
        not_empty = count_reg != '0;
        do_push   = push && !full;
        do_pop    = pop && not_empty;
        pop_entry = mem_reg[rd_ptr_reg];

        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/stsd_back.sv =====
`default_nettype none
module stsd_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire stsd_pkg::back_cfg_t cfg,
    input  wire logic                q_not_empty,
    input  wire stsd_pkg::entry_t    q_entry,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [31:0]              out_start,
    output logic [31:0]              out_end,
    output logic [31:0]              out_value,
    output logic [1:0]               out_kind,
    output logic                     out_error
);

    logic [30:0] count_reg, count_next;
    logic        valid_reg, valid_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] end_reg, end_next;
    logic [31:0] value_reg, value_next;
    logic [1:0]  kind_reg, kind_next;
    logic        error_reg, error_next;

    logic [30:0] count_eff;
    logic [31:0] cs;
    logic [31:0] ce;
    logic        overlap;
    logic        at_limit;
    logic        load;

    always_comb begin
        pop       = q_not_empty && (!valid_reg || out_ready);
        count_eff = q_entry.clr ? 31'd0 : count_reg;

        cs       = (q_entry.start > cfg.range_start) ? q_entry.start : cfg.range_start;
        ce       = (q_entry.stop < cfg.range_end) ? q_entry.stop : cfg.range_end;
        overlap  = cs < ce;
        at_limit = cfg.max_count != 31'd0 && count_eff >= cfg.max_count;

        count_next = count_reg;
        load       = 1'b0;
        start_next = start_reg;
        end_next   = end_reg;
        value_next = value_reg;
        kind_next  = kind_reg;
        error_next = error_reg;

        if (pop) begin
            count_next = count_eff;
            case (q_entry.act)
                stsd_pkg::ACT_ITEM: begin
                    if (overlap && !at_limit) begin
                        load = 1'b1;
                        if (count_eff != '1) begin
                            count_next = count_eff + 31'd1;
                        end
                        start_next = cfg.clip ? cs : q_entry.start;
                        end_next   = cfg.clip ? ce : q_entry.stop;
                        value_next = q_entry.value;
                        kind_next  = q_entry.kind;
                        error_next = 1'b0;
                    end
                end
                stsd_pkg::ACT_ERROR: begin
                    load       = 1'b1;
                    start_next = '0;
                    end_next   = '0;
                    value_next = '0;
                    kind_next  = '0;
                    error_next = 1'b1;
                end
                default: ;
            endcase
        end

        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end

        out_valid = valid_reg;
        out_start = start_reg;
        out_end   = end_reg;
        out_value = value_reg;
        out_kind  = kind_reg;
        out_error = error_reg;
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
        value_reg <= value_next;
        kind_reg  <= kind_next;
        error_reg <= error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire
